[hw/rtl/grs_pkg.sv]
// Package for the group reversal stream block.
// Holds widths, depths and the command/status structs shared by the
// controller and the datapath. Depends on nothing.
package grs_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int MAX_GROUP  = 16;
  localparam int ADDR_W     = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int CNT_W      = $clog2(MAX_GROUP + 1);
  localparam int CFG_W      = 5;

  typedef struct packed {
    logic write;
    logic load;
    logic drop;
  } cmd_t;

  typedef struct packed {
    logic flush;
    logic rd_zero;
    logic out_valid;
  } status_t;

endpackage

[hw/rtl/grs_ctrl.sv]
// Controller for the group reversal stream block.
// Sequences fill and drain of the group store. Depends on grs_pkg.
module grs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             out_ready,
  input  grs_pkg::status_t st,
  output grs_pkg::cmd_t    cmd
);

  localparam logic S_FILL  = 1'b0;
  localparam logic S_DRAIN = 1'b1;

  logic state;
  logic state_next;

  assign in_ready  = (state == S_FILL);
  assign cmd.write = in_valid && in_ready;
  assign cmd.load  = (state == S_DRAIN) && (!st.out_valid || out_ready);
  assign cmd.drop  = st.out_valid && out_ready && !cmd.load;

  always_comb begin
    state_next = state;
    unique case (state)
      S_FILL: begin
        if (cmd.write && st.flush) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (cmd.load && st.rd_zero) state_next = S_FILL;
      end
      default: state_next = S_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FILL;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hw/rtl/grs_datapath.sv]
// Datapath for the group reversal stream block.
// Holds the group store, fill and read counters, the size register and the
// output word register. Depends on grs_pkg.
module grs_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [grs_pkg::CFG_W-1:0]             cfg_wdata,
  input  logic signed [grs_pkg::DATA_WIDTH-1:0] item_value,
  input  logic                                  list_end,
  input  grs_pkg::cmd_t                         cmd,
  output grs_pkg::status_t                      st,
  output logic                                  out_valid,
  output logic signed [grs_pkg::DATA_WIDTH-1:0] out_value,
  output logic                                  group_last,
  output logic                                  list_last
);

  logic signed [grs_pkg::DATA_WIDTH-1:0] store [grs_pkg::MAX_GROUP];
  logic [grs_pkg::CFG_W-1:0]  group_size;
  logic [grs_pkg::CNT_W-1:0]  fill_count;
  logic [grs_pkg::CNT_W-1:0]  count_inc;
  logic [grs_pkg::CNT_W-1:0]  eff_size;
  logic [grs_pkg::ADDR_W-1:0] rd_ptr;
  logic                       end_flag;

  always_comb begin
    if (group_size == '0) begin
      eff_size = grs_pkg::CNT_W'(1);
    end else if ({{grs_pkg::CNT_W{1'b0}}, group_size} >
                 (grs_pkg::CNT_W + grs_pkg::CFG_W)'(grs_pkg::MAX_GROUP)) begin
      eff_size = grs_pkg::CNT_W'(grs_pkg::MAX_GROUP);
    end else begin
      eff_size = grs_pkg::CNT_W'(group_size);
    end
  end

  assign count_inc    = fill_count + grs_pkg::CNT_W'(1);
  assign st.flush     = (count_inc >= eff_size) || list_end;
  assign st.rd_zero   = (rd_ptr == '0);
  assign st.out_valid = out_valid;

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      store[fill_count[grs_pkg::ADDR_W-1:0]] <= item_value;
    end
    if (cmd.load) begin
      out_value  <= store[rd_ptr];
      group_last <= (rd_ptr == '0);
      list_last  <= (rd_ptr == '0) && end_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write && st.flush) begin
      rd_ptr   <= fill_count[grs_pkg::ADDR_W-1:0];
      end_flag <= list_end;
    end else if (cmd.load) begin
      rd_ptr <= rd_ptr - grs_pkg::ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= grs_pkg::CFG_W'(1);
      fill_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) group_size <= cfg_wdata;
      if (cmd.write) fill_count <= st.flush ? '0 : count_inc;
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (cmd.drop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/group_reverse_stream.sv]
// Top level of the group reversal stream block.
// Joins grs_ctrl and grs_datapath. Depends on grs_pkg.
//
// Words are collected into a 16-entry store until group_size words have
// arrived or a word marked list_end is taken; the group is then sent out
// newest first, one word a cycle when out_ready allows. Input is held off
// while a group drains, as the one store holds the group through both
// phases. A group_size of 0 acts as 1 and one above 16 acts as 16; write
// the size only while the block is idle.
module group_reverse_stream (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [grs_pkg::CFG_W-1:0]             cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [grs_pkg::DATA_WIDTH-1:0] item_value,
  input  logic                                  list_end,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [grs_pkg::DATA_WIDTH-1:0] out_value,
  output logic                                  group_last,
  output logic                                  list_last
);

  grs_pkg::cmd_t    cmd;
  grs_pkg::status_t st;

  grs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  grs_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item_value (item_value),
    .list_end   (list_end),
    .cmd        (cmd),
    .st         (st),
    .out_valid  (out_valid),
    .out_value  (out_value),
    .group_last (group_last),
    .list_last  (list_last)
  );

endmodule

[hw/rtl/grs_checker.sv]
// Port-level checks for the group reversal stream block.
// Bound to group_reverse_stream. Depends on grs_pkg.
module grs_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  list_end,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [grs_pkg::DATA_WIDTH-1:0] out_value,
  input logic                                  group_last,
  input logic                                  list_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value)
      && $stable(group_last) && $stable(list_last))
    else $error("output word changed while stalled");

  a_list_in_group: assert property (@(posedge clk) disable iff (rst)
    out_valid && list_last |-> group_last)
    else $error("list end not on a group end");

  a_end_drains: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && list_end |=> !in_ready)
    else $error("input taken after list end before drain");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind group_reverse_stream grs_checker u_grs_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .list_end   (list_end),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_value  (out_value),
  .group_last (group_last),
  .list_last  (list_last)
);
